FILE: hdl/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hdl/tht_pkg.sv
// Shared types and constants of the TCP handshake tracker
`default_nettype none

package tht_pkg;

    localparam int SEQ_W       = 32;
    localparam int TIME_W      = 63;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 136;

    // handshake status codes
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_PARTIAL  = 2'd1;
    localparam logic [1:0] ST_COMPLETE = 2'd2;
    localparam logic [1:0] ST_AMBIG    = 2'd3;

    typedef struct packed {
        logic              session_start;
        logic              direction;
        logic              syn_bit;
        logic              ack_bit;
        logic [SEQ_W-1:0]  seq_number;
        logic [SEQ_W-1:0]  ack_number;
        logic [TIME_W-1:0] time_ns;
    } t_pkt;

    typedef struct packed {
        logic [1:0]        hs_status;
        logic              initiator_known;
        logic              initiator_side;
        logic              synack_rtt_known;
        logic [TIME_W-1:0] synack_delay_ns;
        logic              hs_time_known;
        logic [TIME_W-1:0] hs_time_ns;
        logic              midstream_flag;
        logic              syn_retx_flag;
        logic              regression_flag;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/tht_in_stage.sv
// Input register: captures one packet beat and unpacks it
`default_nettype none

module tht_in_stage
    import tht_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic                  i_take,
    output logic                       o_valid,
    output t_pkt                       o_pkt
);

    logic r_valid;
    t_pkt r_pkt;

    // free when empty or when the held beat moves on this cycle
    assign o_s_axis_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_pkt.session_start <= i_s_axis_tdata[0];
            r_pkt.direction     <= i_s_axis_tdata[1];
            r_pkt.syn_bit       <= i_s_axis_tdata[2];
            r_pkt.ack_bit       <= i_s_axis_tdata[3];
            r_pkt.seq_number    <= i_s_axis_tdata[35:4];
            r_pkt.ack_number    <= i_s_axis_tdata[67:36];
            r_pkt.time_ns       <= i_s_axis_tdata[130:68];
        end
    end

    assign o_valid = r_valid;
    assign o_pkt   = r_pkt;

endmodule

`default_nettype wire

FILE: hdl/tht_core.sv
// Session state and next-state logic of the handshake tracker
`default_nettype none

`include "assert_macros.svh"

module tht_core
    import tht_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire t_pkt i_pkt,
    output t_res      o_res
);

    typedef struct packed {
        logic [1:0]        status;
        logic              init_valid;
        logic              init_side;
        logic              syn_seen;
        logic              syn_dir;
        logic [SEQ_W-1:0]  syn_seq;
        logic [TIME_W-1:0] syn_time;
        logic              synack_seen;
        logic [SEQ_W-1:0]  synack_seq;
        logic              rtt_valid;
        logic [TIME_W-1:0] rtt_value;
        logic              dur_valid;
        logic [TIME_W-1:0] dur_value;
        logic [TIME_W-1:0] max_time;
        logic              regressed;
        logic              fl_mid;
        logic              fl_retx;
        logic              fl_regr;
    } t_state;

    t_state r_st;
    t_state n_st;

    logic [TIME_W:0]  syn_delta;
    logic             before_syn;
    logic             late_pkt;
    logic [SEQ_W-1:0] syn_seq_inc;
    logic [SEQ_W-1:0] synack_seq_inc;

    function automatic t_state f_ambig(input t_state s);
        t_state a;
        a             = s;
        a.status      = ST_AMBIG;
        a.init_valid  = 1'b0;
        a.init_side   = 1'b0;
        a.dur_valid   = 1'b0;
        a.dur_value   = '0;
        a.rtt_valid   = 1'b0;
        a.rtt_value   = '0;
        a.synack_seen = 1'b0;
        return a;
    endfunction

    // one subtractor gives both the delay and the "earlier than SYN" test
    assign syn_delta      = {1'b0, i_pkt.time_ns} - {1'b0, r_st.syn_time};
    assign before_syn     = syn_delta[TIME_W];
    assign late_pkt       = i_pkt.time_ns < r_st.max_time;
    assign syn_seq_inc    = r_st.syn_seq + SEQ_W'(1);
    assign synack_seq_inc = r_st.synack_seq + SEQ_W'(1);

    always_comb begin
        n_st = r_st;
        if (i_pkt.session_start) begin
            n_st          = '0;
            n_st.max_time = i_pkt.time_ns;
            if (i_pkt.syn_bit && !i_pkt.ack_bit) begin
                n_st.status     = ST_PARTIAL;
                n_st.init_valid = 1'b1;
                n_st.init_side  = i_pkt.direction;
                n_st.syn_seen   = 1'b1;
                n_st.syn_dir    = i_pkt.direction;
                n_st.syn_seq    = i_pkt.seq_number;
                n_st.syn_time   = i_pkt.time_ns;
            end else begin
                n_st.fl_mid = 1'b1;
                if (i_pkt.syn_bit) begin
                    // SYN-ACK first: initiator is the other side
                    n_st.status     = ST_PARTIAL;
                    n_st.init_valid = 1'b1;
                    n_st.init_side  = !i_pkt.direction;
                end
            end
        end else if (late_pkt) begin
            n_st           = f_ambig(r_st);
            n_st.fl_regr   = 1'b1;
            n_st.regressed = 1'b1;
        end else begin
            n_st.max_time = i_pkt.time_ns;
            if (!r_st.regressed) begin
                if (r_st.syn_seen && i_pkt.syn_bit && !i_pkt.ack_bit) begin
                    n_st = f_ambig(n_st);
                    if (i_pkt.direction == r_st.syn_dir && i_pkt.seq_number == r_st.syn_seq) begin
                        n_st.fl_retx = 1'b1;
                    end
                end else if (r_st.status != ST_AMBIG && r_st.status != ST_NONE
                             && r_st.syn_seen) begin
                    if (!r_st.synack_seen) begin
                        if (i_pkt.direction != r_st.syn_dir && i_pkt.syn_bit
                            && i_pkt.ack_bit && i_pkt.ack_number == syn_seq_inc) begin
                            if (before_syn) begin
                                n_st = f_ambig(n_st);
                            end else begin
                                n_st.synack_seen = 1'b1;
                                n_st.synack_seq  = i_pkt.seq_number;
                                n_st.rtt_valid   = 1'b1;
                                n_st.rtt_value   = syn_delta[TIME_W-1:0];
                            end
                        end
                    end else if (r_st.status != ST_COMPLETE && i_pkt.direction == r_st.syn_dir
                                 && !i_pkt.syn_bit && i_pkt.ack_bit
                                 && i_pkt.ack_number == synack_seq_inc) begin
                        if (before_syn) begin
                            n_st = f_ambig(n_st);
                        end else begin
                            n_st.status    = ST_COMPLETE;
                            n_st.dur_valid = 1'b1;
                            n_st.dur_value = syn_delta[TIME_W-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_adv) begin
            r_st <= n_st;
        end
    end

    always_comb begin
        o_res.hs_status        = n_st.status;
        o_res.initiator_known  = n_st.init_valid;
        o_res.initiator_side   = n_st.init_valid & n_st.init_side;
        o_res.synack_rtt_known = n_st.rtt_valid;
        o_res.synack_delay_ns  = n_st.rtt_valid ? n_st.rtt_value : '0;
        o_res.hs_time_known    = n_st.dur_valid;
        o_res.hs_time_ns       = n_st.dur_valid ? n_st.dur_value : '0;
        o_res.midstream_flag   = n_st.fl_mid;
        o_res.syn_retx_flag    = n_st.fl_retx;
        o_res.regression_flag  = n_st.fl_regr;
    end

    `ASSERT_PROP(a_regr_ambig, i_clk, i_rst_n, r_st.regressed |-> r_st.status == ST_AMBIG, "regressed session not ambiguous")
    `ASSERT_PROP(a_complete_meas, i_clk, i_rst_n, r_st.status == ST_COMPLETE |-> (r_st.rtt_valid && r_st.dur_valid), "complete handshake without both delays")
    `ASSERT_PROP(a_synack_needs_syn, i_clk, i_rst_n, r_st.synack_seen |-> r_st.syn_seen, "SYN-ACK matched without a SYN")
    `ASSERT_ALWAYS(a_init_clear, i_clk, !r_st.init_valid |-> !r_st.init_side, "initiator side set while unknown")

endmodule

`default_nettype wire

FILE: hdl/tht_out_stage.sv
// Result register: holds one result beat until the sink takes it
`default_nettype none

module tht_out_stage
    import tht_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire t_res                   i_res,
    output logic                        o_free,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    logic r_valid;
    t_res r_res;

    assign o_free = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {1'b0, r_res.regression_flag, r_res.syn_retx_flag,
                              r_res.midstream_flag, r_res.hs_time_ns, r_res.hs_time_known,
                              r_res.synack_delay_ns, r_res.synack_rtt_known,
                              r_res.initiator_side, r_res.initiator_known, r_res.hs_status};

endmodule

`default_nettype wire

FILE: hdl/tcp_handshake_tracker.sv
// Top level of the TCP three-way handshake tracker
`default_nettype none

// Passive monitor of one TCP session's three-way handshake. Each input beat is one observed
// packet header; each produces exactly one result beat with the handshake view after it.
// A beat with session_start set clears all session state first. Throughput is one packet
// per clock while the sink takes every result beat; the accepting edge fills the input
// register, then the combinational state update loads the result register, which offers
// the beat, once free. While a result waits on the sink the input register takes one more
// beat, then holds s_axis_tready low; s_axis_tready follows m_axis_tready combinationally.

module tcp_handshake_tracker
    import tht_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // from bit 0: session_start, direction, syn_bit, ack_bit, seq_number[32],
    // ack_number[32], time_ns[63], zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // from bit 0: hs_status[2], initiator_known, initiator_side, synack_rtt_known,
    // synack_delay_ns[63], hs_time_known, hs_time_ns[63], midstream_flag, syn_retx_flag,
    // regression_flag, zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    logic in_valid;
    t_pkt in_pkt;
    logic out_free;
    logic adv;
    t_res core_res;

    assign adv = in_valid && out_free;

    tht_in_stage u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_take          (adv),
        .o_valid         (in_valid),
        .o_pkt           (in_pkt)
    );

    tht_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_pkt   (in_pkt),
        .o_res   (core_res)
    );

    tht_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (adv),
        .i_res           (core_res),
        .o_free          (out_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
